### sv/hsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_pkg
// shared types and constants of the hive slot container
// ----------------------------------------------------------------------------
package hsc_pkg;

    localparam int SLOTS_PER_BLOCK = 32;
    localparam int MAX_BLOCKS      = 8;
    localparam int VALUE_WIDTH     = 32;
    localparam int TOTAL_SLOTS     = SLOTS_PER_BLOCK * MAX_BLOCKS;
    localparam int SLOT_W          = $clog2(SLOTS_PER_BLOCK);
    localparam int BLK_W           = $clog2(MAX_BLOCKS);
    localparam int ADDR_W          = SLOT_W + BLK_W;
    localparam int LINK_W          = SLOT_W + 1;
    localparam int CNT_W           = $clog2(TOTAL_SLOTS + 1);
    localparam int OPEN_W          = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [2:0] {
        MODE_INSERT    = 3'd0,
        MODE_ERASE_POS = 3'd1,
        MODE_ERASE_VAL = 3'd2,
        MODE_CLEAR     = 3'd3,
        MODE_FIRST     = 3'd4,
        MODE_NEXT      = 3'd5
    } mode_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] element_value;
        logic [2:0]  position_block;
        logic [4:0]  position_slot;
        logic        position_valid;
    } in_word_t;

    typedef struct packed {
        logic        result_ok;
        logic [31:0] result_value;
        logic [2:0]  result_block;
        logic [4:0]  result_slot;
        logic        result_has_position;
        logic [8:0]  element_count;
        logic [3:0]  open_block_count;
    } out_word_t;

    // memory access request from the sequencer
    typedef struct packed {
        logic              wr_elem;
        logic              wr_link;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       elem;
        logic [LINK_W-1:0] link;
    } mem_req_t;

endpackage
`default_nettype wire

### sv/hive_slot_container.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hive_slot_container
// hive container of element words with per-block free lists
// ----------------------------------------------------------------------------
// in (in_word_t) carries one command word: insert, erase at a position,
// erase by value, clear, first, next. out (out_word_t) returns exactly one
// result word per command, with the live and open block counts.
// One command at a time: in_ready is high only while the sequencer idles.
// Insert reads the head link of the chosen block, then writes the element
// there; a new block first has its 32 links written. Erase at position
// reads the element of a live slot. First, next and erase by value step
// slot by slot, skip dead slots and read each live one, which erase by value
// compares. Clear rewrites the links of every open block; rejected commands
// go straight to the result. The single-port element and link memories pace
// these steps. Dead bits, free-list heads and counts sit in flip-flops.
// Reset empties the container: no block open, all slots dead. A stalled
// out_ready holds the result word in the output register; the next
// command is accepted once the result has been taken.
// ----------------------------------------------------------------------------
module hive_slot_container (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire hsc_pkg::in_word_t in,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output hsc_pkg::out_word_t     out
);
    localparam int SW = hsc_pkg::SLOT_W;
    localparam int BW = hsc_pkg::BLK_W;
    localparam int AW = hsc_pkg::ADDR_W;
    localparam int LW = hsc_pkg::LINK_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FMT, ST_INS_RD, ST_INS_WAIT, ST_INS_WR,
        ST_ERP_RD, ST_ERP_WAIT, ST_SCAN, ST_SCAN_WAIT, ST_CLR, ST_OUT
    } state_t;

    state_t                       state_reg;
    hsc_pkg::in_word_t            cmd_reg;
    logic [hsc_pkg::TOTAL_SLOTS-1:0] dead_reg;
    logic [LW-1:0]                head_reg [hsc_pkg::MAX_BLOCKS];
    logic [hsc_pkg::OPEN_W-1:0]   open_reg;
    logic [hsc_pkg::CNT_W-1:0]    live_reg;
    logic [AW:0]                  ptr_reg;
    logic [BW-1:0]                blk_reg;
    logic [SW:0]                  idx_reg;
    hsc_pkg::out_word_t           out_reg;
    logic                         out_valid_reg;
    hsc_pkg::mem_req_t            req;
    logic [31:0]                  elem_q;
    logic [LW-1:0]                link_q;

    hsc_store u_store (
        .clk    (clk),
        .req    (req),
        .elem_q (elem_q),
        .link_q (link_q)
    );

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out       = out_reg;

    // first block with a free slot
    logic            room_any;
    logic [BW-1:0]   room_blk;
    always_comb
    begin
        room_any = 1'b0;
        room_blk = '0;
        for (int b = hsc_pkg::MAX_BLOCKS - 1; b >= 0; b--)
        begin
            if ((b < int'(open_reg)) &&
                (head_reg[b] < LW'(hsc_pkg::SLOTS_PER_BLOCK)))
            begin
                room_any = 1'b1;
                room_blk = BW'(b);
            end
        end
    end

    logic [AW-1:0] ptr_a;
    logic [AW-1:0] blk_addr;
    logic          ptr_in;
    logic          val_zero;
    logic          push_free;
    assign ptr_a    = ptr_reg[AW-1:0];
    assign blk_addr = {blk_reg, idx_reg[SW-1:0]};
    assign ptr_in   = (ptr_reg < (AW+1)'(int'(open_reg) * hsc_pkg::SLOTS_PER_BLOCK));
    assign val_zero = (cmd_reg.element_value == '0);
    // a successful erase pushes its slot on the free list
    assign push_free = out_reg.result_ok && !out_reg.result_has_position &&
                       (cmd_reg.mode == hsc_pkg::MODE_ERASE_POS ||
                        cmd_reg.mode == hsc_pkg::MODE_ERASE_VAL);

    // memory port drive
    always_comb
    begin
        req = '0;
        req.elem = cmd_reg.element_value;
        unique case (state_reg)
            ST_FMT, ST_CLR:
            begin
                req.addr    = blk_addr;
                req.wr_link = 1'b1;
                req.link    = LW'(idx_reg) + LW'(1);
            end
            ST_INS_RD, ST_INS_WAIT:
                req.addr = {blk_reg, head_reg[blk_reg][SW-1:0]};
            ST_INS_WR:
            begin
                req.addr    = {blk_reg, head_reg[blk_reg][SW-1:0]};
                req.wr_elem = 1'b1;
            end
            ST_ERP_RD, ST_ERP_WAIT, ST_SCAN, ST_SCAN_WAIT:
                req.addr = ptr_a;
            ST_OUT:
            begin
                req.addr    = ptr_a;
                req.wr_link = push_free;
                req.link    = head_reg[ptr_a[AW-1:SW]];
            end
            default:
                req.addr = '0;
        endcase
    end

    function automatic hsc_pkg::out_word_t fail_word(
        input logic [hsc_pkg::CNT_W-1:0] live, input logic [hsc_pkg::OPEN_W-1:0] opn);
        hsc_pkg::out_word_t w;
        w = '0;
        w.element_count    = 9'(live);
        w.open_block_count = 4'(opn);
        return w;
    endfunction

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dead_reg      <= '1;
            open_reg      <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < hsc_pkg::MAX_BLOCKS; b++)
            begin
                head_reg[b] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        cmd_reg <= in;
                        out_reg <= fail_word(live_reg, open_reg);
                        idx_reg <= '0;
                        blk_reg <= '0;
                        ptr_reg <= '0;
                        priority case (in.mode)
                            hsc_pkg::MODE_INSERT:
                            begin
                                if (in.element_value == '0)
                                    state_reg <= ST_OUT;
                                else if (room_any)
                                begin
                                    blk_reg   <= room_blk;
                                    state_reg <= ST_INS_RD;
                                end
                                else if (int'(open_reg) < hsc_pkg::MAX_BLOCKS)
                                begin
                                    blk_reg   <= BW'(open_reg);
                                    head_reg[BW'(open_reg)] <= '0;
                                    open_reg  <= open_reg + 1'b1;
                                    state_reg <= ST_FMT;
                                end
                                else
                                    state_reg <= ST_OUT;
                            end
                            hsc_pkg::MODE_ERASE_POS:
                            begin
                                ptr_reg <= {1'b0, in.position_block, in.position_slot};
                                if (in.position_valid &&
                                    ({1'b0, in.position_block} < open_reg) &&
                                    !dead_reg[{in.position_block, in.position_slot}])
                                    state_reg <= ST_ERP_RD;
                                else
                                    state_reg <= ST_OUT;
                            end
                            hsc_pkg::MODE_ERASE_VAL:
                                state_reg <= (in.element_value == '0) ? ST_OUT : ST_SCAN;
                            hsc_pkg::MODE_CLEAR:
                            begin
                                out_reg.result_ok <= 1'b1;
                                out_reg.element_count <= '0;
                                live_reg <= '0;
                                dead_reg <= '1;
                                for (int b = 0; b < hsc_pkg::MAX_BLOCKS; b++)
                                begin
                                    head_reg[b] <= '0;
                                end
                                state_reg <= (open_reg == '0) ? ST_OUT : ST_CLR;
                            end
                            hsc_pkg::MODE_FIRST:
                                state_reg <= ST_SCAN;
                            hsc_pkg::MODE_NEXT:
                            begin
                                ptr_reg <= {1'b0, in.position_block, in.position_slot}
                                           + (AW+1)'(1);
                                if (in.position_valid &&
                                    ({1'b0, in.position_block} < open_reg))
                                    state_reg <= ST_SCAN;
                                else
                                    state_reg <= ST_OUT;
                            end
                            default:
                                state_reg <= ST_OUT;
                        endcase
                    end
                end
                // write the initial chain of a new block
                ST_FMT:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (SW+1)'(hsc_pkg::SLOTS_PER_BLOCK - 1))
                        state_reg <= ST_INS_RD;
                end
                ST_CLR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (SW+1)'(hsc_pkg::SLOTS_PER_BLOCK - 1))
                    begin
                        idx_reg <= '0;
                        blk_reg <= blk_reg + 1'b1;
                        if ({1'b0, blk_reg} + 1'b1 >= open_reg)
                            state_reg <= ST_OUT;
                    end
                end
                ST_INS_RD:   state_reg <= ST_INS_WAIT;
                ST_INS_WAIT: state_reg <= ST_INS_WR;
                ST_INS_WR:
                begin
                    head_reg[blk_reg] <= link_q;
                    dead_reg[{blk_reg, head_reg[blk_reg][SW-1:0]}] <= 1'b0;
                    live_reg <= live_reg + 1'b1;
                    out_reg.result_ok <= 1'b1;
                    out_reg.result_value <= cmd_reg.element_value;
                    out_reg.result_block <= 3'(blk_reg);
                    out_reg.result_slot <= 5'(head_reg[blk_reg]);
                    out_reg.result_has_position <= 1'b1;
                    out_reg.element_count <= 9'(live_reg + 1'b1);
                    out_reg.open_block_count <= 4'(open_reg);
                    state_reg <= ST_OUT;
                end
                ST_ERP_RD: state_reg <= ST_ERP_WAIT;
                ST_ERP_WAIT:
                begin
                    out_reg.result_ok    <= 1'b1;
                    out_reg.result_value <= elem_q;
                    out_reg.result_block <= 3'(ptr_a[AW-1:SW]);
                    out_reg.result_slot  <= 5'(ptr_a[SW-1:0]);
                    state_reg <= ST_OUT;
                end
                // one slot per pass; live slots read their element
                ST_SCAN:
                begin
                    if (!ptr_in)
                        state_reg <= ST_OUT;
                    else if (dead_reg[ptr_a])
                        ptr_reg <= ptr_reg + 1'b1;
                    else
                        state_reg <= ST_SCAN_WAIT;
                end
                ST_SCAN_WAIT:
                begin
                    if (cmd_reg.mode != hsc_pkg::MODE_ERASE_VAL)
                    begin
                        out_reg.result_ok    <= 1'b1;
                        out_reg.result_value <= elem_q;
                        out_reg.result_block <= 3'(ptr_a[AW-1:SW]);
                        out_reg.result_slot  <= 5'(ptr_a[SW-1:0]);
                        out_reg.result_has_position <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else if (elem_q == cmd_reg.element_value && !val_zero)
                    begin
                        out_reg.result_ok    <= 1'b1;
                        out_reg.result_value <= elem_q;
                        out_reg.result_block <= 3'(ptr_a[AW-1:SW]);
                        out_reg.result_slot  <= 5'(ptr_a[SW-1:0]);
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg + 1'b1;
                        state_reg <= ST_SCAN;
                    end
                end
                // erases push the slot here, while the link port is free
                ST_OUT:
                begin
                    if (push_free)
                    begin
                        head_reg[ptr_a[AW-1:SW]] <= {1'b0, ptr_a[SW-1:0]};
                        dead_reg[ptr_a] <= 1'b1;
                        live_reg <= live_reg - 1'b1;
                        out_reg.element_count <= 9'(live_reg - 1'b1);
                    end
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result count never exceeds the open capacity
    a_live_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(out.element_count) <=
                       int'(out.open_block_count) * hsc_pkg::SLOTS_PER_BLOCK))
        else $error("live count above open capacity");

    // no command accepted while a result is pending
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready with result pending");

    // failed results carry no position
    a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out.result_ok) |-> !out.result_has_position)
        else $error("position on failed result");
endmodule
`default_nettype wire

### sv/hsc_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_store
// element and free-link memories, one port each, registered read
// ----------------------------------------------------------------------------
module hsc_store (
    input  wire logic                       clk,
    input  wire hsc_pkg::mem_req_t          req,
    output logic [31:0]                     elem_q,
    output logic [hsc_pkg::LINK_W-1:0]      link_q
);
    logic [31:0]                elem_mem [hsc_pkg::TOTAL_SLOTS];
    logic [hsc_pkg::LINK_W-1:0] link_mem [hsc_pkg::TOTAL_SLOTS];

    // element store
    always_ff @(posedge clk)
    begin
        if (req.wr_elem)
        begin
            elem_mem[req.addr] <= req.elem;
        end
        elem_q <= elem_mem[req.addr];
    end

    // free-link store
    always_ff @(posedge clk)
    begin
        if (req.wr_link)
        begin
            link_mem[req.addr] <= req.link;
        end
        link_q <= link_mem[req.addr];
    end
endmodule
`default_nettype wire
